@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker, clocked on clk; SUNR_ASSERT is quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SUNR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check a property on every rising edge, reset included.
`define SUNR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) \
		else $error(msg);

`endif

@@ hw/rtl/sunr_pkg.sv @@
`timescale 1ns / 1ps

package sunr_pkg;

	localparam int MAX_DIM_DEF = 30000;
	localparam logic [31:0] MAGIC = 32'h59a66a95;

	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int TDATA_W = 80;

	typedef enum logic [2:0] {
		KIND_HEADER  = 3'd0,
		KIND_PALETTE = 3'd1,
		KIND_PIXEL   = 3'd2,
		KIND_DONE    = 3'd3,
		KIND_ERROR   = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ERR_MAGIC      = 4'd0,
		ERR_WIDTH      = 4'd1,
		ERR_HEIGHT     = 4'd2,
		ERR_DEPTH      = 4'd3,
		ERR_TYPE       = 4'd4,
		ERR_MAPTYPE    = 4'd5,
		ERR_COMPRESSED = 4'd6,
		ERR_TOO_MANY   = 4'd7,
		ERR_TRUNCATED  = 4'd8
	} err_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_MAP    = 2'd1,
		PH_PIXELS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       start;
		logic       fin;
	} beat_t;

	typedef struct packed {
		kind_t       kind;
		err_t        error_code;
		logic [14:0] image_width;
		logic [14:0] image_height;
		logic [5:0]  bits_per_pixel;
		logic [1:0]  map_kind;
		logic [1:0]  channel;
		logic [7:0]  entry_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        line_end;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

@@ hw/rtl/sun_raster_stream_decoder.sv @@
`timescale 1ns / 1ps
// An accepted byte is registered, decoded, and its results queued. Throughput: one byte
// per cycle, held back only while the eight-entry result queue is more than half full;
// a byte with two results adds two entries, drained one per cycle while m_tready is high.
// Reset: arst_n low clears the parser to the header phase and empties the result queue.
// A byte flagged as file start restarts parsing with that byte.

module sun_raster_stream_decoder #(
	parameter int MAX_DIM = sunr_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // data_byte
	input  logic                          s_tuser,   // file_start
	input  logic                          s_tlast,   // file_end
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// error_code, image_width, image_height, bits_per_pixel, map_kind, channel,
	// entry_index, red, green, blue, zero fill
	output logic [sunr_pkg::TDATA_W-1:0]  m_tdata,
	output logic [2:0]                    m_tuser,   // kind
	output logic                          m_tlast    // line_end
);

	sunr_pkg::beat_t beat_s1;
	sunr_pkg::push_t push;
	sunr_pkg::res_t  head;

	sunr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.in_start (s_tuser),
		.in_fin   (s_tlast),
		.beat_s1  (beat_s1)
	);

	sunr_decode #(
		.MAX_DIM (MAX_DIM)
	) u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat_s1 (beat_s1),
		.push    (push)
	);

	sunr_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.head      (head)
	);

	assign m_tdata = {4'b0000, head.blue, head.green, head.red, head.entry_index,
	                  head.channel, head.map_kind, head.bits_per_pixel, head.image_height,
	                  head.image_width, head.error_code};
	assign m_tuser = head.kind;
	assign m_tlast = head.line_end;

endmodule

@@ hw/rtl/sunr_in_reg.sv @@
`timescale 1ns / 1ps

module sunr_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         in_data,
	input  logic               in_start,
	input  logic               in_fin,
	output sunr_pkg::beat_t    beat_s1
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       start_s1;
	logic       fin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid & in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= in_data;
			start_s1 <= in_start;
			fin_s1   <= in_fin;
		end
	end

	assign beat_s1 = '{valid: valid_s1, data: data_s1, start: start_s1, fin: fin_s1};

endmodule

@@ hw/rtl/sunr_decode.sv @@
`timescale 1ns / 1ps

module sunr_decode #(
	parameter int MAX_DIM = sunr_pkg::MAX_DIM_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sunr_pkg::beat_t  beat_s1,
	output sunr_pkg::push_t  push
);

	localparam logic [1:0] MAP_RGB = 2'd1;

	typedef struct packed {
		logic [16:0] data_len;
		logic [16:0] line_len;
		logic [16:0] end_col;
	} geom_t;

	typedef struct packed {
		sunr_pkg::phase_t phase;
		logic             halted;
		logic [4:0]       hc;
		logic [31:0]      gather;
		logic [14:0]      width;
		logic [14:0]      height;
		logic [5:0]       depth;
		logic [1:0]       mkind;
		logic [31:0]      remain;
		logic [8:0]       entries;
		logic [7:0]       pent;
		logic [1:0]       chan;
		logic [16:0]      col;
		logic [14:0]      row;
		logic [15:0]      held;
		logic [1:0]       k;
		logic [16:0]      data_len;
		logic [16:0]      line_len;
		logic [16:0]      end_col;
	} st_t;

	// Bytes per line with and without padding, and the column count after the last pixel byte.
	function automatic geom_t geom_of(input logic [14:0] w, input logic [5:0] d);
		logic [16:0] w17;
		logic [16:0] w3;
		logic [16:0] w15;
		geom_t       g;
		w17 = {2'b00, w};
		w3  = w17 + {1'b0, w, 1'b0};
		w15 = w17 + 17'd15;
		unique case (d)
			6'd1: begin
				g.data_len = (w17 + 17'd7) >> 3;
				g.line_len = {3'b000, w15[16:4], 1'b0};
				g.end_col  = g.data_len;
			end
			6'd8: begin
				g.data_len = w17;
				g.line_len = (w17 + 17'd1) & 17'h1fffe;
				g.end_col  = w17;
			end
			6'd24: begin
				g.data_len = w3;
				g.line_len = (w3 + 17'd1) & 17'h1fffe;
				g.end_col  = w3;
			end
			default: begin
				g.data_len = {w, 2'b00};
				g.line_len = {w, 2'b00};
				g.end_col  = {w, 2'b00} - 17'd1;
			end
		endcase
		return g;
	endfunction

	st_t               st_q;
	st_t               cur;
	st_t               nxt;
	sunr_pkg::res_t    res [2];
	logic [1:0]        nres;
	logic [31:0]       word;
	logic [19:0]       prod;
	logic              too_many;
	geom_t             geom;
	logic              hfail;
	sunr_pkg::err_t    hcode;
	logic              emit_hdr;
	logic              emit_pal;
	logic              emit_pix;
	logic              emit_done;
	logic              enter;
	logic [7:0]        pix_red;
	logic [7:0]        pix_green;
	logic [7:0]        pix_blue;
	logic              pix_le;
	logic [8:0]        ent_inc;
	logic [16:0]       c_next;
	logic [14:0]       row_next;
	logic              deep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (beat_s1.valid) begin
			st_q <= nxt;
		end
	end

	always_comb begin
		if (beat_s1.start) begin
			cur = '0;
			cur.phase = sunr_pkg::PH_HEADER;
		end else begin
			cur = st_q;
		end
	end

	assign word     = {cur.gather[23:0], beat_s1.data};
	assign prod     = 20'(word[9:0]) * 20'd683;
	assign geom     = geom_of(cur.width, cur.depth);
	assign ent_inc  = {1'b0, cur.pent} + 9'd1;
	assign c_next   = cur.col + 17'd1;
	assign row_next = cur.row + 15'd1;
	assign deep     = cur.depth[5] | cur.depth[4];

	always_comb begin
		unique case (cur.depth)
			6'd1:    too_many = word >= 32'd9;
			6'd8:    too_many = word >= 32'd771;
			default: too_many = word >= 32'd3;
		endcase
		too_many = too_many && (cur.mkind == MAP_RGB);
	end

	always_comb begin
		nxt       = cur;
		nres      = 2'd0;
		res[0]    = '0;
		res[1]    = '0;
		hfail     = 1'b0;
		hcode     = sunr_pkg::ERR_MAGIC;
		emit_hdr  = 1'b0;
		emit_pal  = 1'b0;
		emit_pix  = 1'b0;
		emit_done = 1'b0;
		enter     = 1'b0;
		pix_red   = beat_s1.data;
		pix_green = 8'd0;
		pix_blue  = 8'd0;
		pix_le    = 1'b0;

		if (beat_s1.valid && !cur.halted) begin
			unique case (cur.phase)
				sunr_pkg::PH_HEADER: begin
					nxt.gather = word;
					nxt.hc     = cur.hc + 5'd1;
					if (cur.hc[1:0] == 2'b11) begin
						unique case (cur.hc[4:2])
							3'd0: begin
								hfail = word != sunr_pkg::MAGIC;
								hcode = sunr_pkg::ERR_MAGIC;
							end
							3'd1: begin
								hfail     = word > 32'(MAX_DIM);
								hcode     = sunr_pkg::ERR_WIDTH;
								nxt.width = word[14:0];
							end
							3'd2: begin
								hfail      = word > 32'(MAX_DIM);
								hcode      = sunr_pkg::ERR_HEIGHT;
								nxt.height = word[14:0];
							end
							3'd3: begin
								hfail     = !(word == 32'd1 || word == 32'd8 ||
								              word == 32'd24 || word == 32'd32);
								hcode     = sunr_pkg::ERR_DEPTH;
								nxt.depth = word[5:0];
							end
							3'd4: begin
								// image length carries nothing we need
							end
							3'd5: begin
								hfail = (word > 32'd5) || (word == 32'd2);
								hcode = (word > 32'd5) ? sunr_pkg::ERR_TYPE
								                       : sunr_pkg::ERR_COMPRESSED;
							end
							3'd6: begin
								hfail     = word > 32'd2;
								hcode     = sunr_pkg::ERR_MAPTYPE;
								nxt.mkind = word[1:0];
							end
							3'd7: begin
								hfail = too_many;
								hcode = sunr_pkg::ERR_TOO_MANY;
								if (!too_many) begin
									emit_hdr     = 1'b1;
									nxt.remain   = word;
									nxt.pent     = 8'd0;
									nxt.chan     = 2'd0;
									nxt.entries  = (cur.mkind == MAP_RGB) ? prod[19:11] : 9'd0;
									nxt.data_len = geom.data_len;
									nxt.line_len = geom.line_len;
									nxt.end_col  = geom.end_col;
									if (word == 32'd0) begin
										enter = 1'b1;
									end else begin
										nxt.phase = sunr_pkg::PH_MAP;
									end
								end
							end
						endcase
					end
				end
				sunr_pkg::PH_MAP: begin
					if (cur.chan != 2'd3 && cur.entries != 9'd0) begin
						emit_pal = 1'b1;
						if (ent_inc >= cur.entries) begin
							nxt.pent = 8'd0;
							nxt.chan = cur.chan + 2'd1;
						end else begin
							nxt.pent = ent_inc[7:0];
						end
					end
					nxt.remain = cur.remain - 32'd1;
					if (cur.remain == 32'd1) begin
						enter = 1'b1;
					end
				end
				sunr_pkg::PH_PIXELS: begin
					if (cur.col < cur.data_len) begin
						if (!deep) begin
							emit_pix = 1'b1;
							pix_le   = c_next == cur.data_len;
						end else begin
							// stored order is blue, green, red, then an unused byte at depth 32
							unique case (cur.k)
								2'd0: nxt.held = {8'd0, beat_s1.data};
								2'd1: nxt.held = {beat_s1.data, cur.held[7:0]};
								2'd2: begin
									emit_pix  = 1'b1;
									pix_green = cur.held[15:8];
									pix_blue  = cur.held[7:0];
									pix_le    = c_next == cur.end_col;
								end
								default: begin
								end
							endcase
							if ((cur.k == 2'd2 && cur.depth[4]) || cur.k == 2'd3) begin
								nxt.k = 2'd0;
							end else begin
								nxt.k = cur.k + 2'd1;
							end
						end
					end
					nxt.col = c_next;
					if (c_next == cur.line_len) begin
						nxt.col = 17'd0;
						nxt.k   = 2'd0;
						nxt.row = row_next;
						if (row_next == cur.height) begin
							nxt.phase = sunr_pkg::PH_DONE;
							emit_done = 1'b1;
						end
					end
				end
				sunr_pkg::PH_DONE: begin
				end
			endcase

			if (enter) begin
				nxt.col  = 17'd0;
				nxt.row  = 15'd0;
				nxt.held = 16'd0;
				nxt.k    = 2'd0;
				if (cur.height == 15'd0 || cur.width == 15'd0) begin
					nxt.phase = sunr_pkg::PH_DONE;
					emit_done = 1'b1;
				end else begin
					nxt.phase = sunr_pkg::PH_PIXELS;
				end
			end
		end

		if (hfail) begin
			res[nres[0]].kind       = sunr_pkg::KIND_ERROR;
			res[nres[0]].error_code = hcode;
			nres                    = nres + 2'd1;
			nxt.halted              = 1'b1;
		end
		if (emit_hdr) begin
			res[nres[0]].kind           = sunr_pkg::KIND_HEADER;
			res[nres[0]].image_width    = cur.width;
			res[nres[0]].image_height   = cur.height;
			res[nres[0]].bits_per_pixel = cur.depth;
			res[nres[0]].map_kind       = cur.mkind;
			nres                        = nres + 2'd1;
		end
		if (emit_pal) begin
			res[nres[0]].kind        = sunr_pkg::KIND_PALETTE;
			res[nres[0]].channel     = cur.chan;
			res[nres[0]].entry_index = cur.pent;
			res[nres[0]].red         = beat_s1.data;
			nres                     = nres + 2'd1;
		end
		if (emit_pix) begin
			res[nres[0]].kind     = sunr_pkg::KIND_PIXEL;
			res[nres[0]].red      = pix_red;
			res[nres[0]].green    = pix_green;
			res[nres[0]].blue     = pix_blue;
			res[nres[0]].line_end = pix_le;
			nres                  = nres + 2'd1;
		end
		if (emit_done) begin
			res[nres[0]].kind = sunr_pkg::KIND_DONE;
			nres              = nres + 2'd1;
		end

		// end of file before done: flag it, then ignore bytes until the next start
		if (beat_s1.valid && beat_s1.fin) begin
			if (!nxt.halted && nxt.phase != sunr_pkg::PH_DONE) begin
				res[nres[0]].kind       = sunr_pkg::KIND_ERROR;
				res[nres[0]].error_code = sunr_pkg::ERR_TRUNCATED;
				nres                    = nres + 2'd1;
			end
			nxt.halted = 1'b1;
		end
	end

	assign push = '{n: nres, r0: res[0], r1: res[1]};

endmodule

@@ hw/rtl/sunr_out_fifo.sv @@
`timescale 1ns / 1ps

module sunr_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  sunr_pkg::push_t  push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output sunr_pkg::res_t   head
);

	sunr_pkg::res_t                 mem_q [sunr_pkg::FIFO_DEPTH];
	logic [sunr_pkg::PTR_W-1:0]     wp_q;
	logic [sunr_pkg::PTR_W-1:0]     rp_q;
	logic [sunr_pkg::CNT_W-1:0]     cnt_q;
	logic                           pop;

	assign pop       = out_valid & out_ready;
	assign out_valid = cnt_q != '0;
	assign head      = mem_q[rp_q];
	// keep space for the beat in flight and the one taken now, two results each
	assign room      = cnt_q <= sunr_pkg::CNT_W'(sunr_pkg::FIFO_DEPTH - 4);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[sunr_pkg::PTR_W'(wp_q + 1'b1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= sunr_pkg::PTR_W'(wp_q + push.n);
			rp_q  <= sunr_pkg::PTR_W'(rp_q + pop);
			cnt_q <= sunr_pkg::CNT_W'(cnt_q + push.n - pop);
		end
	end

endmodule

@@ hw/rtl/sunr_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sunr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [7:0]                    s_tdata,
	input logic                          s_tuser,
	input logic                          s_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [sunr_pkg::TDATA_W-1:0]  m_tdata,
	input logic [2:0]                    m_tuser,
	input logic                          m_tlast
);

	// a stalled result beat holds
	`SUNR_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed under stall")

	// line end only rides on pixels
	`SUNR_ASSERT(a_line_end, m_tvalid && m_tlast |-> m_tuser == sunr_pkg::KIND_PIXEL, "line end on a non-pixel beat")

	// error beats carry a known code and nothing else
	`SUNR_ASSERT(a_error, m_tvalid && m_tuser == sunr_pkg::KIND_ERROR |-> m_tdata[3:0] <= 4'd8 && m_tdata[79:4] == '0, "bad error beat")

	// a reported header has a depth that passed its check
	`SUNR_ASSERT(a_depth, m_tvalid && m_tuser == sunr_pkg::KIND_HEADER |-> m_tdata[39:34] == 6'd1 || m_tdata[39:34] == 6'd8 || m_tdata[39:34] == 6'd24 || m_tdata[39:34] == 6'd32, "header depth out of set")

	// palette channels stop after blue
	`SUNR_ASSERT(a_channel, m_tvalid && m_tuser == sunr_pkg::KIND_PALETTE |-> m_tdata[43:42] != 2'd3, "palette channel past blue")

endmodule

bind sun_raster_stream_decoder sunr_checker u_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int RAND_BYTES  = 340;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_WAIT  = 16;

	class raster_scoreboard;
		sunr_pkg::res_t   pending[$];
		int               errors;
		sunr_pkg::phase_t stage;
		logic             halted;
		logic [4:0]       hdr_count;
		logic [31:0]      gather, width_w, height_w, depth_w, map_kind_w;
		logic [31:0]      map_left, map_entries, pal_entry, pal_channel, column, row;
		logic [15:0]      held;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			stage       = sunr_pkg::PH_HEADER;
			halted      = 1'b0;
			hdr_count   = '0;
			gather      = '0;
			width_w     = '0;
			height_w    = '0;
			depth_w     = '0;
			map_kind_w  = '0;
			map_left    = '0;
			map_entries = '0;
			pal_entry   = '0;
			pal_channel = '0;
			column      = '0;
			row         = '0;
			held        = '0;
		endfunction

		function logic [31:0] data_span(logic [31:0] depth, logic [31:0] width);
			case (depth)
				32'd1:   return (width + 32'd7) >> 3;
				32'd8:   return width;
				32'd24:  return width * 32'd3;
				default: return width * 32'd4;
			endcase
		endfunction

		// stored line length: 1-bit lines pad to 16 pixels, 32-bit lines never pad
		function logic [31:0] line_span(logic [31:0] depth, logic [31:0] width);
			if (depth == 32'd1)
				return ((width + 32'd15) >> 4) * 32'd2;
			if (depth == 32'd32)
				return width * 32'd4;
			return (data_span(depth, width) + 32'd1) & ~32'd1;
		endfunction

		function void raise_error(sunr_pkg::err_t code);
			sunr_pkg::res_t r;
			r            = '0;
			r.kind       = sunr_pkg::KIND_ERROR;
			r.error_code = code;
			pending.push_back(r);
			halted = 1'b1;
		endfunction

		function void start_pixels();
			sunr_pkg::res_t r;
			column = '0;
			row    = '0;
			held   = '0;
			if (height_w == 32'd0 || line_span(depth_w, width_w) == 32'd0) begin
				stage  = sunr_pkg::PH_DONE;
				r      = '0;
				r.kind = sunr_pkg::KIND_DONE;
				pending.push_back(r);
			end else begin
				stage = sunr_pkg::PH_PIXELS;
			end
		endfunction

		function void header_byte(logic [7:0] b);
			logic [2:0]     idx;
			logic [31:0]    w, allowed;
			sunr_pkg::res_t r;
			gather    = {gather[23:0], b};
			idx       = hdr_count[4:2];
			hdr_count = hdr_count + 5'd1;
			if (hdr_count[1:0] != 2'd0)
				return;
			w = gather;
			case (idx)
				3'd0: if (w != sunr_pkg::MAGIC) raise_error(sunr_pkg::ERR_MAGIC);
				3'd1: begin
					if (w > sunr_pkg::MAX_DIM_DEF)
						raise_error(sunr_pkg::ERR_WIDTH);
					else
						width_w = w;
				end
				3'd2: begin
					if (w > sunr_pkg::MAX_DIM_DEF)
						raise_error(sunr_pkg::ERR_HEIGHT);
					else
						height_w = w;
				end
				3'd3: begin
					if (w != 32'd1 && w != 32'd8 && w != 32'd24 && w != 32'd32)
						raise_error(sunr_pkg::ERR_DEPTH);
					else
						depth_w = w;
				end
				3'd5: begin
					if (w > 32'd5)
						raise_error(sunr_pkg::ERR_TYPE);
					else if (w == 32'd2)
						raise_error(sunr_pkg::ERR_COMPRESSED);
				end
				3'd6: begin
					if (w > 32'd2)
						raise_error(sunr_pkg::ERR_MAPTYPE);
					else
						map_kind_w = w;
				end
				3'd7: begin
					allowed     = (depth_w <= 32'd8) ? (32'd1 << depth_w) : 32'd0;
					map_entries = (map_kind_w == 32'd1) ? w / 32'd3 : 32'd0;
					if (map_entries > allowed) begin
						raise_error(sunr_pkg::ERR_TOO_MANY);
					end else begin
						r                = '0;
						r.kind           = sunr_pkg::KIND_HEADER;
						r.image_width    = width_w[14:0];
						r.image_height   = height_w[14:0];
						r.bits_per_pixel = depth_w[5:0];
						r.map_kind       = map_kind_w[1:0];
						pending.push_back(r);
						map_left    = w;
						pal_entry   = '0;
						pal_channel = '0;
						if (w == 32'd0)
							start_pixels();
						else
							stage = sunr_pkg::PH_MAP;
					end
				end
				default: ;
			endcase
		endfunction

		function void map_byte(logic [7:0] b);
			sunr_pkg::res_t r;
			if (pal_channel < 32'd3 && map_entries != 32'd0) begin
				r             = '0;
				r.kind        = sunr_pkg::KIND_PALETTE;
				r.channel     = pal_channel[1:0];
				r.entry_index = pal_entry[7:0];
				r.red         = b;
				pending.push_back(r);
				pal_entry = pal_entry + 32'd1;
				if (pal_entry >= map_entries) begin
					pal_entry   = '0;
					pal_channel = pal_channel + 32'd1;
				end
			end
			map_left = map_left - 32'd1;
			if (map_left == 32'd0)
				start_pixels();
		endfunction

		function void pixel_byte(logic [7:0] b);
			logic [31:0]    c, last, k, last_pix;
			sunr_pkg::res_t r;
			c    = column;
			last = data_span(depth_w, width_w);
			if (c < last) begin
				if (depth_w == 32'd1 || depth_w == 32'd8) begin
					r          = '0;
					r.kind     = sunr_pkg::KIND_PIXEL;
					r.red      = b;
					r.line_end = (c + 32'd1 == last);
					pending.push_back(r);
				end else begin
					// stored order is B, G, R (then a dropped byte at depth 32)
					k        = (depth_w == 32'd24) ? c % 32'd3 : (c & 32'd3);
					last_pix = (depth_w == 32'd24) ? last - 32'd1 : last - 32'd2;
					case (k)
						32'd0: held = {8'h00, b};
						32'd1: held = {b, held[7:0]};
						32'd2: begin
							r          = '0;
							r.kind     = sunr_pkg::KIND_PIXEL;
							r.red      = b;
							r.green    = held[15:8];
							r.blue     = held[7:0];
							r.line_end = (c == last_pix);
							pending.push_back(r);
						end
						default: ;
					endcase
				end
			end
			column = c + 32'd1;
			if (column >= line_span(depth_w, width_w)) begin
				column = '0;
				row    = row + 32'd1;
				if (row >= height_w) begin
					stage  = sunr_pkg::PH_DONE;
					r      = '0;
					r.kind = sunr_pkg::KIND_DONE;
					pending.push_back(r);
				end
			end
		endfunction

		// returns 1 when the byte was parsed rather than ignored
		function bit note_byte(logic [7:0] b, logic st, logic fn);
			bit took;
			if (st)
				restart();
			took = !halted && stage != sunr_pkg::PH_DONE;
			if (!halted) begin
				case (stage)
					sunr_pkg::PH_HEADER: header_byte(b);
					sunr_pkg::PH_MAP:    map_byte(b);
					sunr_pkg::PH_PIXELS: pixel_byte(b);
					default:             ;
				endcase
			end
			if (fn) begin
				if (!halted && stage != sunr_pkg::PH_DONE)
					raise_error(sunr_pkg::ERR_TRUNCATED);
				halted = 1'b1;
			end
			return took;
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_beat(logic [2:0] kind, logic [sunr_pkg::TDATA_W-1:0] data,
		                         logic last);
			sunr_pkg::res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat, kind %0h data %h", $time, kind, data);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare("kind", want.kind, kind);
			compare("error_code", want.error_code, data[3:0]);
			compare("image_width", want.image_width, data[18:4]);
			compare("image_height", want.image_height, data[33:19]);
			compare("bits_per_pixel", want.bits_per_pixel, data[39:34]);
			compare("map_kind", want.map_kind, data[41:40]);
			compare("channel", want.channel, data[43:42]);
			compare("entry_index", want.entry_index, data[51:44]);
			compare("red", want.red, data[59:52]);
			compare("green", want.green, data[67:60]);
			compare("blue", want.blue, data[75:68]);
			compare("line_end", want.line_end, last);
		endfunction
	endclass

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic [7:0]                   s_tdata  = 8'h00;
	logic                         s_tuser  = 1'b0;
	logic                         s_tlast  = 1'b0;
	logic                         s_tready;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [sunr_pkg::TDATA_W-1:0] m_tdata;
	logic [2:0]                   m_tuser;
	logic                         m_tlast;

	raster_scoreboard sb = new();
	logic             hold_rx   = 1'b0;
	bit               hold_req  = 1'b0;
	int               idle_pct  = 0;
	int               stall_pct = 0;
	int               consumed  = 0;
	int unsigned      cycles    = 0;
	logic [7:0]       file_bytes[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sun_raster_stream_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tuser, m_tdata, m_tlast);
		m_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);
	end

	// hold the result side off once so the queue fills and input stalls
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic st, input logic fn);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= st;
		s_tlast  <= fn;
		do @(posedge clk); while (!s_tready);
		void'(sb.note_byte(b, st, fn));
		consumed++;
	endtask

	task automatic add_word(input logic [31:0] w);
		file_bytes.push_back(w[31:24]);
		file_bytes.push_back(w[23:16]);
		file_bytes.push_back(w[15:8]);
		file_bytes.push_back(w[7:0]);
	endtask

	function automatic logic [31:0] oversize();
		case ($urandom_range(2))
			0:       return sunr_pkg::MAX_DIM_DEF + 1 + $urandom_range(3);
			1:       return 32'hffff_ffff;
			default: return $urandom() | 32'h0010_0000;
		endcase
	endfunction

	task automatic send_file(input int keep, input bit with_fin);
		for (int i = 0; i < keep; i++)
			send_byte(file_bytes[i], i == 0, with_fin && i == keep - 1);
	endtask

	task automatic random_file(input bit full_palette);
		int unsigned w, h, d, map_t, mlen, entries, ftype, fault, body, ends, v;
		logic [31:0] magic_w, wv, hv, dv, tv, mtv;
		file_bytes.delete();
		case ($urandom_range(3))
			0:       d = 1;
			1:       d = 8;
			2:       d = 24;
			default: d = 32;
		endcase
		w = (d == 1) ? $urandom_range(0, 20) : $urandom_range(0, 5);
		h = $urandom_range(0, 2);
		if ($urandom_range(9) == 0) begin
			// extreme dimensions, kept cheap by an empty other axis
			if ($urandom_range(1)) begin
				w = sunr_pkg::MAX_DIM_DEF;
				h = 0;
			end else begin
				w = 0;
				h = sunr_pkg::MAX_DIM_DEF;
			end
		end
		map_t   = $urandom_range(2);
		entries = 0;
		if (map_t == 1 && d <= 8)
			entries = $urandom_range(0, (d == 1) ? 2 : 5);
		mlen = 3 * entries + $urandom_range(0, 2);
		v     = $urandom_range(0, 4);
		ftype = (v >= 2) ? v + 1 : v;
		fault = ($urandom_range(99) < 35) ? $urandom_range(1, 7) : 0;
		if (full_palette) begin
			d     = 8;
			w     = 2;
			h     = 1;
			map_t = 1;
			mlen  = 768;
			fault = 0;
		end
		magic_w = sunr_pkg::MAGIC;
		wv      = w;
		hv      = h;
		dv      = d;
		tv      = ftype;
		mtv     = map_t;
		case (fault)
			1: magic_w = sunr_pkg::MAGIC ^ (32'd1 << $urandom_range(31));
			2: wv = oversize();
			3: hv = oversize();
			4: begin
				dv = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 40);
				if (dv == 1 || dv == 8 || dv == 24 || dv == 32)
					dv = 0;
			end
			5: begin
				case ($urandom_range(2))
					0:       tv = 2;
					1:       tv = $urandom_range(6, 300);
					default: tv = 32'hffff_ffff;
				endcase
			end
			6: mtv = $urandom_range(1) ? $urandom_range(3, 9) : 32'hffff_ffff;
			7: begin
				mtv = 1;
				if (d == 1)
					mlen = 3 * $urandom_range(3, 5) + $urandom_range(0, 2);
				else if (d == 8)
					mlen = 3 * 257 + $urandom_range(0, 2);
				else
					mlen = 3 * $urandom_range(1, 4);
			end
			default: ;
		endcase
		add_word(magic_w);
		add_word(wv);
		add_word(hv);
		add_word(dv);
		add_word($urandom());
		add_word(tv);
		add_word(mtv);
		add_word(mlen);
		if (fault == 0) begin
			body = mlen + h * sb.line_span(d, w);
			repeat (body) file_bytes.push_back(8'($urandom_range(255)));
		end
		// a few bytes past the end, which the block drops
		if ($urandom_range(9) == 0 || fault != 0)
			repeat ($urandom_range(0, 2)) file_bytes.push_back(8'($urandom_range(255)));
		ends = full_palette ? 99 : $urandom_range(99);
		if (ends < 12)
			send_file($urandom_range(1, file_bytes.size() - 1), 1'b1);
		else if (ends < 20)
			send_file($urandom_range(1, file_bytes.size()), 1'b0);
		else
			send_file(file_bytes.size(), 1'b1);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00, 1'b0, 1'b0);  // stray byte before any file start
		send_byte(8'hff, 1'b1, 1'b0);  // bad magic
		repeat (3) send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'hff, 1'b0, 1'b1);
		send_byte(8'h59, 1'b1, 1'b0);  // file ends inside the magic word
		send_byte(8'ha6, 1'b0, 1'b0);
		send_byte(8'h6a, 1'b0, 1'b1);
		send_byte(8'h00, 1'b1, 1'b1);  // start and end on one byte
		send_byte(8'h95, 1'b0, 1'b0);
		random_file(1'b1);             // full 256-entry colormap

		consumed = 0;
		hold_req = 1'b1;
		while (consumed < RAND_BYTES) begin
			case (consumed * 4 / RAND_BYTES)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 52;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 52;
				end
				default: begin
					idle_pct  = 26;
					stall_pct = 26;
				end
			endcase
			if ($urandom_range(19) == 0) begin
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
						$urandom_range(3) == 0);
			end else begin
				random_file(1'b0);
			end
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$display("%0t: %0d expected beats never arrived", $time, sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
